// ===== design/pfc_pkg.sv =====
// Package for the pixel format convert / raster op / blend block.
// Holds format codes, status codes and the conversion functions; no dependencies.
`default_nettype none
package pfc_pkg;

    localparam logic [4:0] FMT_INVALID = 5'd0;
    localparam logic [4:0] FMT_BITMAP1 = 5'd1;
    localparam logic [4:0] FMT_PAL8    = 5'd3;
    localparam logic [4:0] FMT_GRAY2   = 5'd4;
    localparam logic [4:0] FMT_GRAY4   = 5'd5;
    localparam logic [4:0] FMT_GRAY8   = 5'd6;
    localparam logic [4:0] FMT_RGB332  = 5'd7;
    localparam logic [4:0] FMT_BGR233  = 5'd8;
    localparam logic [4:0] FMT_RGB565  = 5'd9;
    localparam logic [4:0] FMT_BGR565  = 5'd10;
    localparam logic [4:0] FMT_RGB888  = 5'd11;
    localparam logic [4:0] FMT_BGR888  = 5'd12;
    localparam logic [4:0] FMT_RGBA    = 5'd13;
    localparam logic [4:0] FMT_ARGB    = 5'd14;
    localparam logic [4:0] FMT_BGRA    = 5'd15;
    localparam logic [4:0] FMT_ABGR    = 5'd16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_NOSUP = 2'd2;

    localparam logic [2:0] OP_COPY  = 3'd0;
    localparam logic [2:0] OP_OR    = 3'd1;
    localparam logic [2:0] OP_AND   = 3'd2;
    localparam logic [2:0] OP_XOR   = 3'd3;
    localparam logic [2:0] OP_BLEND = 3'd4;

    localparam logic [2:0] REG_DEST_FMT = 3'd0;
    localparam logic [2:0] REG_SRC_FMT  = 3'd1;
    localparam logic [2:0] REG_TINT     = 3'd2;
    localparam logic [2:0] REG_TINT_FMT = 3'd3;
    localparam logic [2:0] REG_ROP      = 3'd4;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    typedef struct packed {
        logic [31:0] pix;
        logic [1:0]  st;
    } t_conv;

    typedef struct packed {
        logic [4:0]  dest_fmt;
        logic [4:0]  src_fmt;
        logic [31:0] tint;
        logic [4:0]  tint_fmt;
        logic [2:0]  rop;
    } t_cfg;

    // x*255/n for small x: tables of the truncated results.
    function automatic logic [7:0] exp3(input logic [2:0] x);
        logic [7:0] t;
        case (x)
            3'd0: t = 8'd0;   3'd1: t = 8'd36;  3'd2: t = 8'd72;  3'd3: t = 8'd109;
            3'd4: t = 8'd145; 3'd5: t = 8'd182; 3'd6: t = 8'd218; default: t = 8'd255;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] exp2(input logic [1:0] x);
        logic [7:0] t;
        case (x)
            2'd0: t = 8'd0; 2'd1: t = 8'd85; 2'd2: t = 8'd170; default: t = 8'd255;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] exp4(input logic [3:0] x);
        return {x, x};
    endfunction

    // x*255/31 is 8x plus the truncated 7x/31, which steps up at
    // x = 5, 9, 14, 18, 23, 27 and 31.
    function automatic logic [7:0] exp5(input logic [4:0] x);
        logic [2:0] f;
        f = {2'd0, x >= 5'd5}  + {2'd0, x >= 5'd9}  + {2'd0, x >= 5'd14} +
            {2'd0, x >= 5'd18} + {2'd0, x >= 5'd23} + {2'd0, x >= 5'd27} +
            {2'd0, x >= 5'd31};
        return {x, 3'd0} + {5'd0, f};
    endfunction

    // x*255/63 is 4x plus the truncated x/21.
    function automatic logic [7:0] exp6(input logic [5:0] x);
        logic [1:0] f;
        f = {1'b0, x >= 6'd21} + {1'b0, x >= 6'd42} + {1'b0, x >= 6'd63};
        return {x, 2'd0} + {6'd0, f};
    endfunction

    // c*31/255 and c*63/255, truncated.
    function automatic logic [4:0] red5(input logic [7:0] c);
        logic [12:0] p;
        logic [12:0] q;
        p = 13'(c) * 13'd31;
        q = 13'((21'(p) * 21'd257) >> 16);
        if ((q + 13'd1) * 13'd255 <= p) q = q + 13'd1;
        return q[4:0];
    endfunction

    function automatic logic [5:0] red6(input logic [7:0] c);
        logic [13:0] p;
        logic [13:0] q;
        p = 14'(c) * 14'd63;
        q = 14'((22'(p) * 22'd257) >> 16);
        if ((q + 14'd1) * 14'd255 <= p) q = q + 14'd1;
        return q[5:0];
    endfunction

    function automatic logic [4:0] t3to5(input logic [2:0] x);
        logic [4:0] t;
        case (x)
            3'd0: t = 5'd0;  3'd1: t = 5'd4;  3'd2: t = 5'd9;  3'd3: t = 5'd13;
            3'd4: t = 5'd18; 3'd5: t = 5'd22; 3'd6: t = 5'd27; default: t = 5'd31;
        endcase
        return t;
    endfunction

    function automatic logic [5:0] t3to6(input logic [2:0] x);
        return {x, x};
    endfunction

    function automatic logic [4:0] t2to5(input logic [1:0] x);
        logic [4:0] t;
        case (x)
            2'd0: t = 5'd0; 2'd1: t = 5'd10; 2'd2: t = 5'd21; default: t = 5'd31;
        endcase
        return t;
    endfunction

    function automatic t_rgba unpack(input logic [4:0] f, input logic [31:0] x);
        t_rgba c;
        c.a = 8'd255;
        case (f)
            FMT_RGB332: begin
                c.r = exp3(x[7:5]); c.g = exp3(x[4:2]); c.b = exp2(x[1:0]);
            end
            FMT_BGR233: begin
                c.r = exp3(x[2:0]); c.g = exp3(x[5:3]); c.b = exp2(x[7:6]);
            end
            FMT_RGB565: begin
                c.r = exp5(x[15:11]); c.g = exp6(x[10:5]); c.b = exp5(x[4:0]);
            end
            FMT_BGR565: begin
                c.r = exp5(x[4:0]); c.g = exp6(x[10:5]); c.b = exp5(x[15:11]);
            end
            FMT_RGB888: begin
                c.r = x[23:16]; c.g = x[15:8]; c.b = x[7:0];
            end
            FMT_BGR888: begin
                c.r = x[7:0]; c.g = x[15:8]; c.b = x[23:16];
            end
            FMT_RGBA: begin
                c.r = x[31:24]; c.g = x[23:16]; c.b = x[15:8]; c.a = x[7:0];
            end
            FMT_ARGB: begin
                c.a = x[31:24]; c.r = x[23:16]; c.g = x[15:8]; c.b = x[7:0];
            end
            FMT_BGRA: begin
                c.b = x[31:24]; c.g = x[23:16]; c.r = x[15:8]; c.a = x[7:0];
            end
            default: begin
                c.a = x[31:24]; c.b = x[23:16]; c.g = x[15:8]; c.r = x[7:0];
            end
        endcase
        return c;
    endfunction

    function automatic logic [31:0] pack(input logic [4:0] f, input t_rgba c);
        logic [31:0] v;
        case (f)
            FMT_RGB332: v = {24'd0, c.r[7:5], c.g[7:5], c.b[7:6]};
            FMT_BGR233: v = {24'd0, c.b[7:6], c.g[7:5], c.r[7:5]};
            FMT_RGB565: v = {16'd0, red5(c.r), red6(c.g), red5(c.b)};
            FMT_BGR565: v = {16'd0, red5(c.b), red6(c.g), red5(c.r)};
            FMT_RGB888: v = {8'd0, c.r, c.g, c.b};
            FMT_BGR888: v = {8'd0, c.b, c.g, c.r};
            FMT_RGBA:   v = {c.r, c.g, c.b, c.a};
            FMT_ARGB:   v = {c.a, c.r, c.g, c.b};
            FMT_BGRA:   v = {c.b, c.g, c.r, c.a};
            default:    v = {c.a, c.b, c.g, c.r};
        endcase
        return v;
    endfunction

    function automatic logic is_gray(input logic [4:0] f);
        return (f == FMT_GRAY2) || (f == FMT_GRAY4) || (f == FMT_GRAY8);
    endfunction

    function automatic t_conv convert(input logic [4:0] fout, input logic [31:0] x,
                                      input logic [4:0] fin);
        t_conv  o;
        t_rgba  c;
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        logic       direct;
        o.pix  = 32'd0;
        o.st   = ST_OK;
        c      = unpack(fin, x);
        direct = 1'b1;
        r5 = 5'd0; g6 = 6'd0; b5 = 5'd0;
        if (fin == FMT_INVALID || fout == FMT_INVALID || fin > FMT_ABGR || fout > FMT_ABGR) begin
            o.st = ST_INVAL;
        end else if ((fout > FMT_BITMAP1 && fout <= FMT_PAL8) ||
                     (fin >= FMT_BITMAP1 && fin <= FMT_PAL8)) begin
            o.st = ST_NOSUP;
        end else if (fin == fout) begin
            o.pix = x;
        end else if (fout == FMT_BITMAP1) begin
            if (fin >= FMT_RGBA)
                o.pix = {31'd0, (c.a != 8'd0) && ((c.r | c.g | c.b) != 8'd0)};
            else
                o.pix = {31'd0, x != 32'd0};
        end else if (is_gray(fout) || is_gray(fin)) begin
            o.st = ST_NOSUP;
        end else if (fout == FMT_RGB332 && fin == FMT_BGR233) begin
            o.pix = {24'd0, x[2:0], x[5:3], x[7:6]};
        end else if (fout == FMT_BGR233 && fin == FMT_RGB332) begin
            o.pix = {24'd0, x[1:0], x[4:2], x[7:5]};
        end else begin
            if (fin == FMT_RGB332) begin
                r5 = t3to5(x[7:5]); g6 = t3to6(x[4:2]); b5 = t2to5(x[1:0]);
            end else if (fin == FMT_BGR233) begin
                r5 = t3to5(x[2:0]); g6 = t3to6(x[5:3]); b5 = t2to5(x[7:6]);
            end else if (fin == FMT_RGB565) begin
                r5 = x[15:11]; g6 = x[10:5]; b5 = x[4:0];
            end else if (fin == FMT_BGR565) begin
                r5 = x[4:0]; g6 = x[10:5]; b5 = x[15:11];
            end else begin
                direct = 1'b0;
            end
            if (direct && fout == FMT_RGB565)
                o.pix = {16'd0, r5, g6, b5};
            else if (direct && fout == FMT_BGR565)
                o.pix = {16'd0, b5, g6, r5};
            else
                o.pix = pack(fout, c);
        end
        return o;
    endfunction

    // Grayscale alpha value from the low bits of a source pixel.
    function automatic logic [7:0] gray_alpha(input logic [4:0] f, input logic [31:0] x);
        logic [7:0] a;
        case (f)
            FMT_GRAY2: a = exp2(x[1:0]);
            FMT_GRAY4: a = exp4(x[3:0]);
            default:   a = x[7:0];
        endcase
        return a;
    endfunction

    // (p)/255 for p < 65280, truncated: reciprocal then one correction.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [15:0] q;
        q = 16'((25'(p) * 25'd257) >> 16);
        if ((17'(q) + 17'd1) * 17'd255 <= 17'(p)) q = q + 16'd1;
        return q[7:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/pixel_format_convert_rop_blend.sv =====
// Top level of the per-pixel blitter stage: configuration registers and pipeline.
// Depends on pfc_pkg, pfc_unpack and pfc_mix.
//
// One transfer on the input channel carries a destination pixel and a source
// pixel; one transfer on the output channel returns the new destination pixel
// and a status code (0 ok, 1 invalid format, 2 not supported). The source is
// converted into the destination format and combined by the configured raster
// operation: copy, OR, AND, XOR or alpha blend. A grayscale source format makes
// the source an alpha mask that tints the configured tint colour.
// The pipeline has four register stages: format unpacking, the alpha products,
// the divide by 255 that finishes the blend, and the output register, which is
// loaded after the repacking into the destination format and the raster
// operation. A pixel passes through these four registers in that order. One pixel
// is taken in every cycle while the output side accepts. When the receiver
// stalls, the whole pipeline holds; input ready is high whenever the output
// register is empty or being emptied, so nothing is lost or repeated.
// Synchronous reset clears the valid bits and returns the registers to their
// defaults: RGBA8888 for all formats, white tint, copy operation. Configuration
// writes take effect at once and are meant to be made while the pipeline is empty.
`default_nettype none
module pixel_format_convert_rop_blend (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_dest_pixel,
    input  wire logic [31:0] i_src_pixel,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result_pixel,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    pfc_pkg::t_cfg  r_cfg;
    logic           en;

    logic           s1_valid;
    pfc_pkg::t_conv s1_direct;
    pfc_pkg::t_rgba s1_bg, s1_fg;
    logic [1:0]     s1_st;
    logic [31:0]    s1_dest;

    pfc_pkg::t_conv r2_direct;
    logic [1:0]     r2_st;
    logic [31:0]    r2_dest;
    logic [7:0]     r2_bga;
    logic           s2_valid;
    logic [15:0]    s2_prod [6];
    pfc_pkg::t_rgba s2_fg;

    pfc_pkg::t_rgba n_mix;
    logic [7:0]     sum_r, sum_g, sum_b;

    pfc_pkg::t_rgba r3_mix;
    pfc_pkg::t_conv r3_direct;
    logic [1:0]     r3_st;
    logic [31:0]    r3_dest;
    logic           r3_valid;

    pfc_pkg::t_conv out_c;
    logic [31:0]    n_res;
    logic [1:0]     n_st;

    logic [31:0]    r_res;
    logic [1:0]     r_st;
    logic           r_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_fmt <= pfc_pkg::FMT_RGBA;
            r_cfg.src_fmt  <= pfc_pkg::FMT_RGBA;
            r_cfg.tint     <= 32'hFFFF_FFFF;
            r_cfg.tint_fmt <= pfc_pkg::FMT_RGBA;
            r_cfg.rop      <= pfc_pkg::OP_COPY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pfc_pkg::REG_DEST_FMT: r_cfg.dest_fmt <= i_cfg_data[4:0];
                pfc_pkg::REG_SRC_FMT:  r_cfg.src_fmt  <= i_cfg_data[4:0];
                pfc_pkg::REG_TINT:     r_cfg.tint     <= i_cfg_data;
                pfc_pkg::REG_TINT_FMT: r_cfg.tint_fmt <= i_cfg_data[4:0];
                pfc_pkg::REG_ROP:      r_cfg.rop      <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register can take a new value.
    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    pfc_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_cfg        (r_cfg),
        .i_dest_pixel (i_dest_pixel),
        .i_src_pixel  (i_src_pixel),
        .o_valid      (s1_valid),
        .o_direct     (s1_direct),
        .o_bg         (s1_bg),
        .o_fg         (s1_fg),
        .o_st         (s1_st),
        .o_dest_pixel (s1_dest)
    );

    pfc_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_bg    (s1_bg),
        .i_fg    (s1_fg),
        .o_valid (s2_valid),
        .o_prod  (s2_prod),
        .o_fg    (s2_fg)
    );

    // Side data travelling alongside the product stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_direct <= s1_direct;
            r2_st     <= s1_st;
            r2_dest   <= s1_dest;
            r2_bga    <= s1_bg.a;
        end
    end

    // Stage three: divide the products by 255 and finish the blend. An opaque
    // foreground passes straight through; otherwise the colour mixes and the
    // destination keeps its own alpha.
    always_comb begin
        sum_r = pfc_pkg::div255(s2_prod[0]) + pfc_pkg::div255(s2_prod[3]);
        sum_g = pfc_pkg::div255(s2_prod[1]) + pfc_pkg::div255(s2_prod[4]);
        sum_b = pfc_pkg::div255(s2_prod[2]) + pfc_pkg::div255(s2_prod[5]);
        if (s2_fg.a == 8'd255) begin
            n_mix = s2_fg;
        end else begin
            n_mix.r = sum_r;
            n_mix.g = sum_g;
            n_mix.b = sum_b;
            n_mix.a = r2_bga;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mix    <= n_mix;
            r3_direct <= r2_direct;
            r3_st     <= r2_st;
            r3_dest   <= r2_dest;
        end
    end

    // Stage four: repack the blend into the destination format and apply the
    // raster operation. Any error status forces a zero pixel.
    always_comb begin
        out_c = pfc_pkg::convert(r_cfg.dest_fmt, r3_mix, pfc_pkg::FMT_RGBA);
        n_res = 32'd0;
        n_st  = pfc_pkg::ST_OK;
        case (r_cfg.rop)
            pfc_pkg::OP_COPY: begin
                n_st = r3_direct.st; n_res = r3_direct.pix;
            end
            pfc_pkg::OP_OR: begin
                n_st = r3_direct.st; n_res = r3_dest | r3_direct.pix;
            end
            pfc_pkg::OP_AND: begin
                n_st = r3_direct.st; n_res = r3_dest & r3_direct.pix;
            end
            pfc_pkg::OP_XOR: begin
                n_st = r3_direct.st; n_res = r3_dest ^ r3_direct.pix;
            end
            pfc_pkg::OP_BLEND: begin
                n_st  = (r3_st != pfc_pkg::ST_OK) ? r3_st : out_c.st;
                n_res = out_c.pix;
            end
            default: n_st = pfc_pkg::ST_NOSUP;
        endcase
        if (n_st != pfc_pkg::ST_OK) n_res = 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else if (en) begin
            r3_valid <= s2_valid;
            r_valid  <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_st  <= n_st;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_pixel = r_res;
    assign o_status       = r_st;
endmodule
`default_nettype wire

// ===== design/pfc_unpack.sv =====
// Stage one: converts the destination and the source or tint into RGBA8888.
// Also converts the source into the destination format. Depends on pfc_pkg.
`default_nettype none
module pfc_unpack (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire pfc_pkg::t_cfg i_cfg,
    input  wire logic [31:0]   i_dest_pixel,
    input  wire logic [31:0]   i_src_pixel,
    output logic               o_valid,
    output pfc_pkg::t_conv     o_direct,
    output pfc_pkg::t_rgba     o_bg,
    output pfc_pkg::t_rgba     o_fg,
    output logic [1:0]         o_st,
    output logic [31:0]        o_dest_pixel
);
    pfc_pkg::t_conv n_direct, bg_c, fg_c;
    pfc_pkg::t_rgba n_fg;
    logic [1:0]     n_st;

    pfc_pkg::t_conv r_direct;
    pfc_pkg::t_rgba r_bg, r_fg;
    logic [1:0]     r_st;
    logic [31:0]    r_dest;
    logic           r_valid;

    always_comb begin
        n_direct = pfc_pkg::convert(i_cfg.dest_fmt, i_src_pixel, i_cfg.src_fmt);
        bg_c     = pfc_pkg::convert(pfc_pkg::FMT_RGBA, i_dest_pixel, i_cfg.dest_fmt);
        if (pfc_pkg::is_gray(i_cfg.src_fmt))
            fg_c = pfc_pkg::convert(pfc_pkg::FMT_RGBA, i_cfg.tint, i_cfg.tint_fmt);
        else
            fg_c = pfc_pkg::convert(pfc_pkg::FMT_RGBA, i_src_pixel, i_cfg.src_fmt);
        n_fg = fg_c.pix;
        if (pfc_pkg::is_gray(i_cfg.src_fmt))
            n_fg.a = pfc_pkg::gray_alpha(i_cfg.src_fmt, i_src_pixel);
        n_st = (bg_c.st != pfc_pkg::ST_OK) ? bg_c.st : fg_c.st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_direct <= n_direct;
            r_bg     <= bg_c.pix;
            r_fg     <= n_fg;
            r_st     <= n_st;
            r_dest   <= i_dest_pixel;
        end
    end

    assign o_valid      = r_valid;
    assign o_direct     = r_direct;
    assign o_bg         = r_bg;
    assign o_fg         = r_fg;
    assign o_st         = r_st;
    assign o_dest_pixel = r_dest;
endmodule
`default_nettype wire

// ===== design/pfc_mix.sv =====
// Stage two: multiplies the colour components by alpha and its complement.
// Depends on pfc_pkg.
`default_nettype none
module pfc_mix (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire pfc_pkg::t_rgba i_bg,
    input  wire pfc_pkg::t_rgba i_fg,
    output logic               o_valid,
    output logic [15:0]        o_prod [6],
    output pfc_pkg::t_rgba     o_fg
);
    logic [7:0]     ia;
    logic [15:0]    r_prod [6];
    pfc_pkg::t_rgba r_fg;
    logic           r_valid;

    assign ia = 8'd255 - i_fg.a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0] <= 16'(i_fg.r) * 16'(i_fg.a);
            r_prod[1] <= 16'(i_fg.g) * 16'(i_fg.a);
            r_prod[2] <= 16'(i_fg.b) * 16'(i_fg.a);
            r_prod[3] <= 16'(i_bg.r) * 16'(ia);
            r_prod[4] <= 16'(i_bg.g) * 16'(ia);
            r_prod[5] <= 16'(i_bg.b) * 16'(ia);
            r_fg      <= i_fg;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_fg    = r_fg;
endmodule
`default_nettype wire
